// ===== rtl/dfia_pkg.sv =====
// Shared constants, codes and types of the deferred free index allocator.
`timescale 1ns / 1ps
package dfia_pkg;

  // Sizing
  localparam int unsigned NUM_SLOTS  = 1024;
  localparam int unsigned NUM_FRAMES = 2;

  // Item field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned FRAME_W  = 1;
  localparam int unsigned STATUS_W = 2;

  // Derived widths
  localparam int unsigned ADDR_W  = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int unsigned FRM_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned DEPTH   = NUM_FRAMES * NUM_SLOTS;
  localparam int unsigned DADDR_W = $clog2(DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SLOT   = 2'd1,
    STAT_LIST_FULL = 2'd2
  } status_e;

  // Request from the front end to the deferred lists
  typedef struct packed {
    logic              append;
    logic              release_frm;
    logic [FRM_W-1:0]  frame;
    logic [SLOT_W-1:0] slot;
  } defer_req_t;

  // Slot pushed back onto the free stack
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } push_t;

  // Frame field folded onto the implemented frames
  function automatic logic [FRM_W-1:0] frm_idx(input logic [FRAME_W-1:0] f);
    return FRM_W'(32'(f) % NUM_FRAMES);
  endfunction

endpackage

// ===== rtl/dfia_if.sv =====
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps
interface dfia_in_if import dfia_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [SLOT_W-1:0]  slot_index;
  logic [FRAME_W-1:0] frame;

  modport source (output valid, mode, slot_index, frame, input ready);
  modport sink   (input valid, mode, slot_index, frame, output ready);
endinterface

interface dfia_out_if import dfia_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   granted_index;
  logic [STATUS_W-1:0] status;

  modport source (output valid, granted_index, status, input ready);
  modport sink   (input valid, granted_index, status, output ready);
endinterface

// ===== rtl/deferred_free_index_allocator.sv =====
// Top level: item decode, result stage and output register of the allocator.
//
// Usage
//   in_i  : items {mode, slot_index, frame}; accepted when valid && ready.
//           mode 0 allocates a slot, 1 queues slot_index on the frame's
//           deferred list, 2 returns that frame's queued slots to the pool.
//   out_o : one result item {granted_index, status} per input item, in order.
// Flow
//   A taken item's result is held in the result stage, then moves on to the
//   output register. Allocate and free items can be taken back to back
//   while the output side keeps up (one read of the free stack memory per
//   allocate). After a release the walker reads one list entry per cycle
//   and writes it to the free stack in the next cycle; in_i.ready stays
//   low until it is done.
// Reset
//   All slots are free and the deferred lists are empty. No clearing pass is
//   run: a high-water mark stands for the identity contents of the stack.
// Stalls
//   With the output register full and out_o.ready low, one more result is
//   held in the result stage; after that in_i.ready drops.
`timescale 1ns / 1ps
module deferred_free_index_allocator import dfia_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dfia_in_if.sink    in_i,
  dfia_out_if.source out_o
);

  logic              accept;
  logic              busy;
  logic              empty;
  logic              full;
  logic              pop;
  logic [FRM_W-1:0]  frm;
  logic [CNT_W-1:0]  used;
  logic [SLOT_W-1:0] top_slot;
  defer_req_t        dreq;
  push_t             push;

  // result stage and output register
  logic              s1_valid_q;
  logic              s1_grant_q;
  status_e           s1_status_q;
  status_e           status_d;
  logic              out_free;
  logic              s1_adv;
  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  status_e           out_status_q;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !busy && (!s1_valid_q || out_free);
  assign accept     = in_i.valid && in_i.ready;

  assign frm   = frm_idx(in_i.frame);
  assign empty = (used == CNT_W'(NUM_SLOTS));

  // Item decode
  always_comb begin
    pop              = 1'b0;
    status_d         = STAT_OK;
    dreq.append      = 1'b0;
    dreq.release_frm = 1'b0;
    dreq.frame       = frm;
    dreq.slot        = in_i.slot_index;
    case (in_i.mode)
      MODE_ALLOC: begin
        if (empty) status_d = STAT_NO_SLOT;
        else       pop      = accept;
      end
      MODE_FREE: begin
        if (full) status_d    = STAT_LIST_FULL;
        else      dreq.append = accept;
      end
      MODE_RELEASE: dreq.release_frm = accept;
      default: status_d = STAT_OK;
    endcase
  end

  dfia_free_stack u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_i      (pop),
    .push_i     (push),
    .used_o     (used),
    .top_slot_o (top_slot)
  );

  dfia_defer_list u_defer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .full_o (full),
    .busy_o (busy),
    .push_o (push)
  );

  // Control of result stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept)      s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv)           out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_grant_q  <= pop;
      s1_status_q <= status_d;
    end
    if (s1_adv) begin
      out_slot_q   <= s1_grant_q ? top_slot : '0;
      out_status_q <= s1_status_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.granted_index = out_slot_q;
  assign out_o.status        = out_status_q;

  // Checks
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_i.ready)
    else $error("item taken while release walks");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= CNT_W'(NUM_SLOTS))
    else $error("used count beyond pool size");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> used == $past(used) + CNT_W'(1))
    else $error("allocate did not advance used count");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_status_q))
    else $error("pending result lost under stall");

endmodule

// ===== rtl/dfia_free_stack.sv =====
// Free slot stack: one memory, used count and high-water mark.
`timescale 1ns / 1ps
module dfia_free_stack import dfia_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_i,
  input  push_t             push_i,
  output logic [CNT_W-1:0]  used_o,
  output logic [SLOT_W-1:0] top_slot_o
);

  logic [SLOT_W-1:0] mem [NUM_SLOTS];

  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  hw_q, hw_d;
  logic [CNT_W-1:0]  used_inc, used_dec;
  logic [SLOT_W-1:0] rd_q, ident_q;
  logic              hit_q;
  logic              do_push;

  assign used_inc = used_q + CNT_W'(1);
  assign used_dec = used_q - CNT_W'(1);
  // a push with nothing in use is dropped
  assign do_push  = push_i.valid && (used_q != '0);

  // Count update; hw tracks the highest count reached. Entries at or above
  // it were never written; their identity value is used in their place.
  always_comb begin
    used_d = used_q;
    hw_d   = hw_q;
    if (pop_i) begin
      used_d = used_inc;
      if (used_inc > hw_q) begin
        hw_d = used_inc;
      end
    end else if (do_push) begin
      used_d = used_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      hw_q   <= '0;
    end else begin
      used_q <= used_d;
      hw_q   <= hw_d;
    end
  end

  // Memory port: read top on pop, write new top on push
  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rd_q    <= mem[used_q[ADDR_W-1:0]];
      hit_q   <= (used_q < hw_q);
      ident_q <= SLOT_W'(used_q);
    end
    if (do_push) begin
      mem[used_dec[ADDR_W-1:0]] <= push_i.slot;
    end
  end

  assign top_slot_o = hit_q ? rd_q : ident_q;
  assign used_o     = used_q;

endmodule

// ===== rtl/dfia_defer_list.sv =====
// Per-frame deferred free lists in one memory, with the release walker.
`timescale 1ns / 1ps
module dfia_defer_list import dfia_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  defer_req_t req_i,
  output logic       full_o,
  output logic       busy_o,
  output push_t      push_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  logic [SLOT_W-1:0]  mem [DEPTH];

  logic [CNT_W-1:0]   cnt_q [NUM_FRAMES];
  logic [CNT_W-1:0]   cur_cnt;
  logic [DADDR_W-1:0] base;
  logic               do_append;

  state_e             state_q, state_d;
  logic [DADDR_W-1:0] rel_base_q;
  logic [CNT_W-1:0]   rel_cnt_q;
  logic [CNT_W-1:0]   idx_q;
  logic               pend_q;
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_q;

  assign cur_cnt   = cnt_q[req_i.frame];
  assign base      = DADDR_W'(req_i.frame) * DADDR_W'(NUM_SLOTS);
  assign full_o    = (cur_cnt == CNT_W'(NUM_SLOTS));
  assign do_append = req_i.append && !full_o;
  assign rd_en     = (state_q == ST_WALK) && (idx_q != rel_cnt_q);

  // Walker: read one entry a cycle, push it back the cycle after
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req_i.release_frm) state_d = ST_WALK;
      ST_WALK: if (!rd_en && !pend_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      idx_q   <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      pend_q  <= rd_en;
      if (req_i.release_frm) begin
        idx_q              <= '0;
        cnt_q[req_i.frame] <= '0;
      end else begin
        if (rd_en) idx_q <= idx_q + CNT_W'(1);
        if (do_append) cnt_q[req_i.frame] <= cur_cnt + CNT_W'(1);
      end
    end
  end

  // Release parameters and memory port
  always_ff @(posedge clk_i) begin
    if (req_i.release_frm) begin
      rel_base_q <= base;
      rel_cnt_q  <= cur_cnt;
    end
    if (do_append) begin
      mem[base + DADDR_W'(cur_cnt)] <= req_i.slot;
    end
    if (rd_en) begin
      rd_q <= mem[rel_base_q + DADDR_W'(idx_q)];
    end
  end

  assign busy_o       = (state_q == ST_WALK);
  assign push_o.valid = pend_q;
  assign push_o.slot  = rd_q;

endmodule

// ===== dv/tb_deferred_free_index_allocator.sv =====
// Testbench of the deferred free index allocator: directed table, random phases, scoreboard.
`timescale 1ns / 1ps
module tb_deferred_free_index_allocator import dfia_pkg::*; ();

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int unsigned       SLOT_MAX   = (1 << SLOT_W) - 1;
  localparam int unsigned       HOLD_CYCLES = 400;
  localparam int unsigned       CYCLE_LIMIT = 1000000;
  localparam int unsigned       DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SLOT_W-1:0]  slot;
    logic [FRAME_W-1:0] frame;
  } slot_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] grant;
    status_e           status;
  } pool_res_t;

  typedef struct packed {
    slot_req_t req;
    logic      known;
    pool_res_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  dfia_in_if  in_bus ();
  dfia_out_if out_bus ();

  deferred_free_index_allocator u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Shadow copy of the slot pool
  logic [SLOT_W-1:0] pool_stack [NUM_SLOTS];
  int unsigned       pool_used;
  logic [SLOT_W-1:0] defer_mem [NUM_FRAMES*NUM_SLOTS];
  int unsigned       defer_cnt [NUM_FRAMES];

  pool_res_t         awaited_results [$];
  logic [SLOT_W-1:0] live_slots [$];
  dir_row_t          dir_rows [$];
  int unsigned       bad_fields;
  int unsigned       cycle_cnt;
  int unsigned       burst_left;
  bit                hold_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
    bad_fields++;
  endtask

  // Apply one item to the shadow pool and return its answer
  task automatic compute_pool_answer(input slot_req_t req, output pool_res_t res);
    int unsigned f;
    f = int'(req.frame) % NUM_FRAMES;
    res.grant  = '0;
    res.status = STAT_OK;
    case (req.mode)
      MODE_ALLOC: begin
        if (pool_used >= NUM_SLOTS) begin
          res.status = STAT_NO_SLOT;
        end else begin
          res.grant = pool_stack[pool_used];
          pool_used++;
        end
      end
      MODE_FREE: begin
        if (defer_cnt[f] >= NUM_SLOTS) begin
          res.status = STAT_LIST_FULL;
        end else begin
          defer_mem[f*NUM_SLOTS + defer_cnt[f]] = req.slot;
          defer_cnt[f]++;
        end
      end
      MODE_RELEASE: begin
        // queued slots go back in queue order; extra ones are dropped at zero
        for (int unsigned i = 0; i < defer_cnt[f]; i++) begin
          if (pool_used > 0) begin
            pool_used--;
            pool_stack[pool_used] = defer_mem[f*NUM_SLOTS + i];
          end
        end
        defer_cnt[f] = 0;
      end
      default: ;
    endcase
  endtask

  function automatic slot_req_t mk_req(input logic [MODE_W-1:0] m, input int s, input int f);
    slot_req_t r;
    r.mode  = m;
    r.slot  = SLOT_W'(s);
    r.frame = FRAME_W'(f);
    return r;
  endfunction

  function automatic void add_row(input logic [MODE_W-1:0] m, input int s, input int f,
                                  input logic known, input int g, input status_e st);
    dir_row_t row;
    row.req        = mk_req(m, s, f);
    row.known      = known;
    row.want.grant = SLOT_W'(g);
    row.want.status = st;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Offer one item in bursts with random gaps; record its answer on acceptance
  task automatic send_req(input slot_req_t req, input logic known, input pool_res_t want);
    int unsigned gap;
    pool_res_t   res;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= req.mode;
    in_bus.slot_index <= req.slot;
    in_bus.frame      <= req.frame;
    do @(posedge clk); while (!in_bus.ready);
    compute_pool_answer(req, res);
    if (req.mode == MODE_ALLOC && res.status == STAT_OK)
      live_slots.insert(live_slots.size(), res.grant);
    awaited_results.insert(awaited_results.size(), known ? want : res);
  endtask

  task automatic send_random(input logic [MODE_W-1:0] m, input int f);
    send_req(mk_req(m, $urandom_range(SLOT_MAX), f), 1'b0, '0);
  endtask

  // Receiver: stall pattern in segments, plus one long hold-off on request
  initial begin : rx_ready
    int unsigned stall_pct;
    int unsigned seg_left;
    stall_pct = 0;
    seg_left  = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          case ($urandom_range(4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 20;
            3:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : chk_results
    pool_res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing pending", int'(out_bus.granted_index), -1);
      end else begin
        want = awaited_results.pop_front();
        if (out_bus.granted_index !== want.grant)
          report_mismatch("granted_index", int'(out_bus.granted_index), int'(want.grant));
        if (out_bus.status !== want.status)
          report_mismatch("status", int'(out_bus.status), int'(want.status));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               awaited_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin : stim
    int unsigned r;
    int unsigned idx;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.mode       = MODE_ALLOC;
    in_bus.slot_index = '0;
    in_bus.frame      = '0;
    hold_req          = 1'b0;
    bad_fields        = 0;
    cycle_cnt         = 0;
    burst_left        = 0;
    pool_used         = 0;
    for (int unsigned i = 0; i < NUM_SLOTS; i++) pool_stack[i] = SLOT_W'(i);
    for (int unsigned i = 0; i < NUM_FRAMES; i++) defer_cnt[i] = 0;

    // Directed: identity order, reuse order, release underflow, unused mode
    add_row(MODE_ALLOC,   0,       0, 1'b1, 0,       STAT_OK);
    add_row(MODE_ALLOC,   0,       0, 1'b1, 1,       STAT_OK);
    add_row(MODE_SPARE,   SLOT_MAX, 1, 1'b1, 0,      STAT_OK);
    add_row(MODE_FREE,    SLOT_MAX, 1, 1'b1, 0,      STAT_OK);
    add_row(MODE_FREE,    0,       1, 1'b0, 0,       STAT_OK);
    add_row(MODE_FREE,    1,       0, 1'b0, 0,       STAT_OK);
    add_row(MODE_RELEASE, 0,       1, 1'b1, 0,       STAT_OK);
    add_row(MODE_ALLOC,   0,       0, 1'b0, 0,       STAT_OK);
    add_row(MODE_ALLOC,   0,       0, 1'b1, SLOT_MAX, STAT_OK);
    add_row(MODE_ALLOC,   0,       0, 1'b0, 0,       STAT_OK);
    add_row(MODE_RELEASE, 0,       0, 1'b0, 0,       STAT_OK);
    add_row(MODE_ALLOC,   0,       0, 1'b0, 0,       STAT_OK);
    add_row(MODE_RELEASE, SLOT_MAX, 0, 1'b0, 0,      STAT_OK);
    add_row(MODE_FREE,    'h155,   1, 1'b0, 0,       STAT_OK);
    add_row(MODE_FREE,    'h2AA,   1, 1'b0, 0,       STAT_OK);
    add_row(MODE_FREE,    SLOT_MAX, 1, 1'b0, 0,      STAT_OK);
    add_row(MODE_FREE,    0,       1, 1'b0, 0,       STAT_OK);
    add_row(MODE_RELEASE, 0,       1, 1'b0, 0,       STAT_OK);
    add_row(MODE_ALLOC,   0,       0, 1'b1, SLOT_MAX, STAT_OK);
    add_row(MODE_ALLOC,   0,       0, 1'b0, 0,       STAT_OK);
    add_row(MODE_ALLOC,   0,       0, 1'b0, 0,       STAT_OK);
    add_row(MODE_ALLOC,   0,       0, 1'b0, 0,       STAT_OK);
    add_row(MODE_SPARE,   0,       0, 1'b1, 0,       STAT_OK);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);

    // Long receiver hold-off while items keep coming
    hold_req = 1'b1;

    // Fill the pool to exhaustion, with frees and the odd release mixed in
    while (pool_used < NUM_SLOTS) begin
      r = $urandom_range(99);
      if (r < 92)      send_random(MODE_ALLOC, 0);
      else if (r < 97) send_random(MODE_FREE, $urandom_range(1));
      else if (r < 98) send_random(MODE_SPARE, $urandom_range(1));
      else             send_random(MODE_RELEASE, $urandom_range(1));
    end
    repeat (5) send_random(MODE_ALLOC, $urandom_range(1));

    // General mix; most frees return slots that were handed out
    repeat (100) begin
      r = $urandom_range(99);
      if (r < 40) begin
        send_random(MODE_ALLOC, $urandom_range(1));
      end else if (r < 75) begin
        if (live_slots.size() > 0 && $urandom_range(3) != 0) begin
          idx = $urandom_range(live_slots.size() - 1);
          send_req(mk_req(MODE_FREE, int'(live_slots[idx]), $urandom_range(1)), 1'b0, '0);
          live_slots.delete(idx);
        end else begin
          send_random(MODE_FREE, $urandom_range(1));
        end
      end else if (r < 90) begin
        send_random(MODE_RELEASE, $urandom_range(1));
      end else begin
        send_random(MODE_SPARE, $urandom_range(1));
      end
    end
    in_bus.valid <= 1'b0;

    // Drain, then give stray results a chance to show up
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_fields == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
